>>> src/wrpf_pkg.sv
// shared constants and types for the waveform recorder peak finder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package wrpf_pkg;
    localparam int DEPTH_DEF        = 4096;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam logic [15:0] RES_RESET = 16'd1600;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_READ   = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_START = 1'b0,
        REG_RES   = 1'b1
    } reg_idx_t;
endpackage
`default_nettype wire

>>> src/waveform_recorder_peak_finder.sv
// waveform recorder with peak finder: sample memory, serial divider, peak walker
// depends on wrpf_pkg
`timescale 1ns / 1ps
`default_nettype none
// flow: append and clear go straight out; read and find run a 34-step restoring divide,
//   an index check and a memory read; a query that misses ends at the index check, a read
//   returns the sample at idx, and find walks to the peak and scales the index to a time
// throughput: one request at a time, the next is taken the cycle after the result leaves
// reset: rst_n async low clears fill count, start, output valid and fsm, resolution to 1600;
//   sample memory is not cleared, only values from filled entries are ever used
module waveform_recorder_peak_finder #(
    parameter int DEPTH        = wrpf_pkg::DEPTH_DEF,
    parameter int SAMPLE_WIDTH = wrpf_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [7:0]                   cfg_index,
    input  wire  [31:0]                  cfg_data,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // command[1:0], sample[SW+1:2], query_time[SW+33:SW+2], zero pad
    input  wire  [((SAMPLE_WIDTH+34+7)/8)*8-1:0] s_tdata,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // value[SW-1:0], result_time[SW+31:SW], hit[SW+32], zero pad
    output logic [((SAMPLE_WIDTH+33+7)/8)*8-1:0] m_tdata
);
    import wrpf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = ((SAMPLE_WIDTH + 33 + 7) / 8) * 8;
    localparam int DSTEPS = 34;  // quotient bits of (2d+res)/(2res)

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DIV   = 9'b000000010,
        ST_CHK   = 9'b000000100,
        ST_RD    = 9'b000001000,
        ST_PAIR  = 9'b000010000,
        ST_WALK  = 9'b000100000,
        ST_MUL   = 9'b001000000,
        ST_SAT   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] start_reg;
    logic [15:0] res_reg;
    logic [CW-1:0] fill_reg;

    logic [SAMPLE_WIDTH-1:0] mem [DEPTH];
    logic [SAMPLE_WIDTH-1:0] rd_data_reg;

    // request capture
    cmd_t                    cmd_reg;
    logic [33:0]             num_reg;   // dividend shifts out, quotient shifts in
    logic [17:0]             rem_reg;
    logic [5:0]              step_reg;
    logic [16:0]             div_reg;   // 2*res
    logic [33:0]             idx_reg;
    logic                    left_reg;  // walk direction
    logic                    first_reg; // first compare of a walk
    logic [SAMPLE_WIDTH-1:0] cur_reg;   // sample at idx
    logic [48:0]             prod_reg;

    logic [SAMPLE_WIDTH-1:0] out_value_reg;
    logic [31:0]             out_time_reg;
    logic                    out_hit_reg;
    logic                    out_valid_reg;

    // memory read address
    logic [AW-1:0] rd_addr;

    wire [15:0] res_eff = (res_reg == 16'd0) ? 16'd1 : res_reg;
    wire [1:0]  in_cmd  = s_tdata[1:0];
    wire [SAMPLE_WIDTH-1:0] in_sample = s_tdata[SAMPLE_WIDTH+1:2];
    wire [31:0] in_time = s_tdata[SAMPLE_WIDTH+33:SAMPLE_WIDTH+2];

    assign cfg_ready = (state_reg == ST_IDLE) && !s_tvalid;
    assign s_tready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = OW'({out_hit_reg, out_time_reg, out_value_reg});

    // one restoring step of the shared divider
    wire [18:0] trial = {rem_reg, num_reg[33]} - {2'b00, div_reg};
    wire        tfit  = !trial[18];

    wire [AW-1:0] idx_a = idx_reg[AW-1:0];
    wire          at_end = left_reg ? (idx_reg == 34'd0)
                                    : (idx_reg + 34'd1 >= {{(34-CW){1'b0}}, fill_reg});
    wire signed [SAMPLE_WIDTH-1:0] cur_s = cur_reg;
    wire signed [SAMPLE_WIDTH-1:0] nb_s  = rd_data_reg;

    always_comb
    begin
        rd_addr = idx_a;
        if (state_reg == ST_PAIR || state_reg == ST_WALK)
            rd_addr = left_reg ? AW'(idx_reg - 34'd1) : AW'(idx_reg + 34'd1);
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready && cmd_t'(in_cmd) == CMD_APPEND && fill_reg < CW'(DEPTH))
            mem[fill_reg[AW-1:0]] <= in_sample;
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid && s_tready)
                state_next = (cmd_t'(in_cmd) == CMD_READ || cmd_t'(in_cmd) == CMD_FIND)
                             ? ST_DIV : ST_OUT;
            ST_DIV:  if (step_reg == 6'(DSTEPS - 1)) state_next = ST_CHK;
            ST_CHK:  state_next = ST_RD;
            ST_RD:   state_next = ST_PAIR;
            ST_PAIR: state_next = ST_WALK;
            ST_WALK: state_next = ST_WALK;
            ST_MUL:  state_next = ST_SAT;
            ST_SAT:  state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_CHK && (out_hit_reg == 1'b0 || idx_reg >= {{(34-CW){1'b0}}, fill_reg}))
            state_next = ST_OUT;
        if (state_reg == ST_WALK)
        begin
            // rd_data_reg holds the neighbor on the walk side
            if (first_reg)
                state_next = (cmd_reg == CMD_READ) ? ST_OUT : ST_PAIR;
            else if (at_end)
                state_next = ST_MUL;
            else if (left_reg ? (nb_s >= cur_s) : (cur_s <= nb_s))
                state_next = ST_PAIR;
            else
                state_next = ST_MUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 32'd0;
            res_reg       <= RES_RESET;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == 8'(REG_START)) start_reg <= cfg_data;
                else if (cfg_index == 8'(REG_RES)) res_reg <= cfg_data[15:0];
            end
            if (m_tvalid && m_tready) out_valid_reg <= 1'b0;
            if (state_reg == ST_OUT) out_valid_reg <= 1'b1;
            if (s_tvalid && s_tready)
            begin
                if (cmd_t'(in_cmd) == CMD_APPEND && fill_reg < CW'(DEPTH))
                    fill_reg <= fill_reg + CW'(1);
                if (cmd_t'(in_cmd) == CMD_CLEAR)
                begin
                    fill_reg  <= '0;
                    start_reg <= 32'd0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                // capture only on a request so a waiting result stays put
                if (s_tvalid && s_tready)
                begin
                    cmd_reg       <= cmd_t'(in_cmd);
                    out_value_reg <= '0;
                    out_time_reg  <= 32'd0;
                    // queries hit when time is at or after start, appends when not full
                    out_hit_reg   <= (cmd_t'(in_cmd) == CMD_READ || cmd_t'(in_cmd) == CMD_FIND)
                                     ? (in_time >= start_reg)
                                     : ((cmd_t'(in_cmd) == CMD_APPEND) &&
                                        (fill_reg < CW'(DEPTH)));
                    // numerator 2d+res
                    num_reg  <= {(33'(in_time - start_reg) << 1)} + 34'(res_eff);
                    rem_reg  <= '0;
                    step_reg <= '0;
                    div_reg  <= {res_eff, 1'b0};
                end
            end
            ST_DIV:
            begin
                rem_reg  <= tfit ? trial[17:0] : {rem_reg[16:0], num_reg[33]};
                num_reg  <= {num_reg[32:0], tfit};
                step_reg <= step_reg + 6'd1;
                if (step_reg == 6'(DSTEPS - 1))
                    idx_reg <= {num_reg[32:0], tfit};
            end
            ST_CHK:
            begin
                if (idx_reg >= {{(34-CW){1'b0}}, fill_reg})
                    out_hit_reg <= 1'b0;
                left_reg  <= 1'b1;
                first_reg <= 1'b1;
            end
            ST_RD:
            begin
                // rd_data_reg holds sample at idx
            end
            ST_PAIR:
            begin
                // neighbor read is issued here, sample at idx taken on entry
                if (first_reg && left_reg)
                    cur_reg <= rd_data_reg;
            end
            ST_WALK:
            begin
                if (first_reg)
                begin
                    first_reg <= 1'b0;
                    if (cmd_reg == CMD_READ)
                        out_value_reg <= cur_reg;
                    // first left test uses strict greater, else turn right and reread
                    if (idx_reg != 34'd0 && nb_s > cur_s)
                    begin
                        cur_reg <= rd_data_reg;
                        idx_reg <= idx_reg - 34'd1;
                    end
                    else
                        left_reg <= 1'b0;
                end
                else if (!at_end && (left_reg ? (nb_s >= cur_s) : (cur_s <= nb_s)))
                begin
                    cur_reg <= rd_data_reg;
                    idx_reg <= left_reg ? idx_reg - 34'd1 : idx_reg + 34'd1;
                end
            end
            ST_MUL: prod_reg <= 49'(idx_reg[32:0]) * 49'(res_eff);
            ST_SAT:
            begin
                if ((prod_reg + 49'(start_reg)) > 49'h0_FFFF_FFFF)
                    out_time_reg <= 32'hFFFF_FFFF;
                else
                    out_time_reg <= 32'(prod_reg + 49'(start_reg));
            end
            ST_OUT: ;
            default: ;
        endcase
    end
endmodule
`default_nettype wire
